// ----- rtl/pilp_pkg.sv -----
// Shared types and constants for the prefixed integer literal parser.
package pilp_pkg;

    // Accumulator width, sign bit included; the magnitude limit is 2^(ACC_WIDTH-1)-1.
    localparam int ACC_WIDTH = 64;

    // Width of the parsed value on the result channel.
    localparam int VALUE_WIDTH = 64;

    // Width of a number base.
    localparam int BASE_WIDTH = 6;

    // Base that the configuration register holds after reset.
    localparam logic [BASE_WIDTH-1:0] RESET_BASE = BASE_WIDTH'(10);

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SYNTAX   = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    // One character of a word.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    // One parse result.
    typedef struct packed {
        t_status                        status;
        logic signed [VALUE_WIDTH-1:0]  value;
    } t_out;

endpackage

// ----- rtl/prefixed_integer_literal_parser.sv -----
// Prefixed integer literal parser: one character per transfer, one result per word.
//
// The block takes one character of a word in every cycle and gives one result for the
// character marked last. A character is registered on input and is parsed there; the
// result is registered from the last character once that one moves on. Sustained
// rate is one character per cycle; a result that still waits stalls input only once the
// last character of the next word sits in the input register. The path that sets the
// clock is the per-character multiply-add of the accumulator by the active base and its
// compare against the magnitude limit.
module prefixed_integer_literal_parser
    import pilp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_wr_en,
    input  logic [BASE_WIDTH-1:0] i_cfg_wr_data
);

    localparam int MAG_W = ACC_WIDTH - 1;
    localparam int SUM_W = MAG_W + BASE_WIDTH + 1;
    localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

    localparam logic [BASE_WIDTH-1:0] BASE_MIN     = BASE_WIDTH'(2);
    localparam logic [BASE_WIDTH-1:0] BASE_MAX     = BASE_WIDTH'(36);
    localparam logic [BASE_WIDTH-1:0] BASE_BIN     = BASE_WIDTH'(2);
    localparam logic [BASE_WIDTH-1:0] BASE_DEC     = BASE_WIDTH'(10);
    localparam logic [BASE_WIDTH-1:0] BASE_HEX     = BASE_WIDTH'(16);
    localparam logic [BASE_WIDTH-1:0] HEX_MAX_BASE = BASE_WIDTH'(33);
    localparam logic [BASE_WIDTH-1:0] DIGIT_NONE   = {BASE_WIDTH{1'b1}};

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [2:0] {
        PH_SIGN,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_Q1,
        PH_Q2,
        PH_QDONE
    } t_phase;

    // Digit value of a character in any base up to 36; DIGIT_NONE for anything else.
    function automatic logic [BASE_WIDTH-1:0] digit_value(input logic [7:0] c);
        logic [BASE_WIDTH-1:0] d;
        d = DIGIT_NONE;
        if (c inside {[8'h30:8'h39]}) begin
            d = BASE_WIDTH'(c - 8'h30);
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = BASE_WIDTH'(c - 8'h61 + 8'd10);
        end else if (c inside {[8'h41:8'h5A]}) begin
            d = BASE_WIDTH'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    // Configuration, input register and word state.
    logic [BASE_WIDTH-1:0] r_default_base;
    logic                  r_in_valid;
    t_in                   r_in;
    t_phase                r_phase, n_phase;
    logic                  r_negative, n_negative;
    logic [BASE_WIDTH-1:0] r_base, n_base;
    logic [MAG_W-1:0]      r_acc, n_acc;
    logic                  r_digit_seen, n_digit_seen;
    logic                  r_error, n_error;
    logic                  r_overflow, n_overflow;
    logic [7:0]            r_lit, n_lit;
    logic                  r_out_valid;
    t_out                  r_out, n_out;

    logic                  advance;
    logic [BASE_WIDTH-1:0] base_eff;
    logic [BASE_WIDTH-1:0] digit;
    logic                  digit_bad;
    logic [SUM_W-1:0]      digit_sum;
    logic                  digit_ovf;
    logic [VALUE_WIDTH-1:0] mag_ext;

    // A character moves on unless it ends a word while the previous result still waits.
    assign advance     = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The base is sampled from the clamped configuration at the first character.
    always_comb begin
        if (r_phase != PH_SIGN) begin
            base_eff = r_base;
        end else if (r_default_base < BASE_MIN) begin
            base_eff = BASE_MIN;
        end else if (r_default_base > BASE_MAX) begin
            base_eff = BASE_MAX;
        end else begin
            base_eff = r_default_base;
        end
    end

    // Multiply-add of the next digit and the magnitude check.
    assign digit     = digit_value(r_in.ch);
    assign digit_bad = digit >= base_eff;
    assign digit_sum = SUM_W'(r_acc) * SUM_W'(base_eff) + SUM_W'(digit);
    assign digit_ovf = digit_sum > SUM_W'(MAG_LIMIT);

    // Next word state for the registered character, and the result it would end with.
    always_comb begin
        logic take_digit;
        take_digit   = 1'b0;
        n_phase      = r_phase;
        n_negative   = r_negative;
        n_base       = base_eff;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_error      = r_error;
        n_overflow   = r_overflow;
        n_lit        = r_lit;

        // A dot is a syntax error even after an overflow.
        if (r_in.ch == CH_DOT) begin
            n_error    = 1'b1;
            n_overflow = 1'b0;
        end

        case (r_phase)
            PH_SIGN, PH_PREFIX: begin
                if (r_phase == PH_SIGN && r_in.ch == CH_MINUS) begin
                    n_negative = 1'b1;
                    n_phase    = PH_PREFIX;
                end else if (r_phase == PH_SIGN && r_in.ch == CH_PLUS) begin
                    n_phase = PH_PREFIX;
                end else if (r_phase == PH_SIGN && r_in.ch == CH_QUOTE) begin
                    n_phase = PH_Q1;
                end else begin
                    n_phase = PH_DIGITS;
                    if (r_in.ch inside {CH_AMP, CH_HASH}) begin
                        n_base = BASE_DEC;
                    end else if (r_in.ch inside {CH_UB, CH_LB, CH_PCT}) begin
                        n_base = BASE_BIN;
                    end else if (r_in.ch inside {CH_UH, CH_LH, CH_DOLLAR}) begin
                        n_base = BASE_HEX;
                    end else if (r_in.ch == CH_QUOTE) begin
                        n_error = 1'b1;
                    end else begin
                        take_digit = 1'b1;
                        if (r_in.ch == CH_ZERO) begin
                            n_phase = PH_ZERO;
                        end
                    end
                end
            end
            PH_ZERO: begin
                n_phase = PH_DIGITS;
                if (r_in.ch inside {CH_UX, CH_LX}) begin
                    if (base_eff < HEX_MAX_BASE) begin
                        n_base       = BASE_HEX;
                        n_acc        = '0;
                        n_digit_seen = 1'b0;
                    end else begin
                        n_error = 1'b1;
                    end
                end else begin
                    take_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                take_digit = 1'b1;
            end
            PH_Q1: begin
                n_lit   = r_in.ch;
                n_phase = PH_Q2;
            end
            PH_Q2: begin
                if (r_in.ch != CH_QUOTE) begin
                    n_error = 1'b1;
                end
                n_phase = PH_QDONE;
            end
            default: begin
                n_error = 1'b1;
            end
        endcase

        // Digit accumulation stops at the first error or overflow.
        if (take_digit) begin
            if (digit_bad) begin
                n_error = 1'b1;
            end else if (!(r_error || r_overflow)) begin
                if (digit_ovf) begin
                    n_overflow = 1'b1;
                end else begin
                    n_acc        = digit_sum[MAG_W-1:0];
                    n_digit_seen = 1'b1;
                end
            end
        end

        // Result of the word if this character ends it.
        mag_ext      = VALUE_WIDTH'(n_acc);
        n_out.status = STATUS_OK;
        n_out.value  = '0;
        if (n_overflow) begin
            n_out.status = STATUS_OVERFLOW;
        end else if (n_error) begin
            n_out.status = STATUS_SYNTAX;
        end else if (n_phase == PH_QDONE) begin
            n_out.value = VALUE_WIDTH'(n_lit);
        end else if (n_phase == PH_Q1 || n_phase == PH_Q2 || !n_digit_seen) begin
            n_out.status = STATUS_SYNTAX;
        end else begin
            n_out.value = n_negative ? -mag_ext : mag_ext;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
    end

    // Control state: configuration, handshake flags and the word being parsed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_base <= RESET_BASE;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_SIGN;
            r_negative     <= 1'b0;
            r_base         <= BASE_DEC;
            r_acc          <= '0;
            r_digit_seen   <= 1'b0;
            r_error        <= 1'b0;
            r_overflow     <= 1'b0;
            r_lit          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_default_base <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && r_in.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (r_in.last) begin
                    r_phase      <= PH_SIGN;
                    r_negative   <= 1'b0;
                    r_base       <= BASE_DEC;
                    r_acc        <= '0;
                    r_digit_seen <= 1'b0;
                    r_error      <= 1'b0;
                    r_overflow   <= 1'b0;
                    r_lit        <= '0;
                end else begin
                    r_phase      <= n_phase;
                    r_negative   <= n_negative;
                    r_base       <= n_base;
                    r_acc        <= n_acc;
                    r_digit_seen <= n_digit_seen;
                    r_error      <= n_error;
                    r_overflow   <= n_overflow;
                    r_lit        <= n_lit;
                end
            end
        end
    end

    // A failed parse never carries a value.
    a_value_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != STATUS_OK |-> r_out.value == '0)
        else $error("result with a failing status carries a nonzero value");

    // A new word starts from a cleared accumulator.
    a_word_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SIGN |-> r_acc == '0 && !r_digit_seen && !r_error && !r_overflow)
        else $error("word state not cleared at the start of a word");

    // The accumulator only holds digits that were counted.
    a_acc_needs_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_digit_seen |-> r_acc == '0)
        else $error("accumulator nonzero without any accepted digit");

    // A word that ends always leaves a result waiting.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last |=> r_out_valid)
        else $error("last character did not produce a result");

endmodule
